### hdl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared widths, register indexes, reset values and bus types for the power
// button sequencer.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int DELAY_W = 16;
    localparam int COUNT_W = DELAY_W + 1;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_ON_HOLD       = 2'd0;
    localparam logic [INDEX_W-1:0] REG_OFF_HOLD      = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SHUTDOWN_WAIT = 2'd2;

    localparam logic [DELAY_W-1:0] ON_HOLD_RESET       = DELAY_W'(1000);
    localparam logic [DELAY_W-1:0] OFF_HOLD_RESET      = DELAY_W'(3000);
    localparam logic [DELAY_W-1:0] SHUTDOWN_WAIT_RESET = DELAY_W'(10000);

    typedef struct packed {
        logic [DELAY_W-1:0] on_hold_ms;
        logic [DELAY_W-1:0] off_hold_ms;
        logic [DELAY_W-1:0] shutdown_wait_ms;
    } cfg_t;

    typedef struct packed {
        logic shutting_down;
        logic system_marked_on;
        logic shutdown_request;
        logic regulator_enable;
    } result_t;

endpackage

### hdl/power_button_sequencer.sv
// ----------------------------------------------------------------------------
// power_button_sequencer
// Millisecond-tick power sequencer with stream input and output.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick and yields exactly one result
// transaction. A tick is captured in an input register. Once the output register
// is free, the sequencer state is updated from it and the result lands in the
// output register, from which it is offered on the master side. One
// tick is taken every cycle while the result side keeps up; the single state
// update per cycle sets that rate. Delay registers reset to 1000, 3000 and
// 10000 ms and should be written only while no tick is in flight.
module power_button_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] button_pressed, [1] low_voltage

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] regulator_enable,
                                                   // [1] shutdown_request,
                                                   // [2] system_marked_on,
                                                   // [3] shutting_down

    input  logic                        cfg_we,
    input  logic [pbs_pkg::INDEX_W-1:0] cfg_index,
    input  logic [pbs_pkg::DELAY_W-1:0] cfg_data
);

    pbs_pkg::cfg_t    cfg;
    pbs_pkg::result_t result;

    logic       in_valid_reg;
    logic [1:0] in_data_reg;
    logic       out_valid_reg;
    logic [3:0] out_data_reg;
    logic       advance;

    // Advance the tick into the output register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[1:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    pbs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbs_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .button_pressed (in_data_reg[0]),
        .low_voltage    (in_data_reg[1]),
        .cfg            (cfg),
        .result         (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // An empty output stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // The request level is raised and dropped together with the shutdown phase
    a_request_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1] == m_tdata[3]))
        else $error("shutdown request out of step with shutdown phase");

    // A captured tick reaches the output stage in the next cycle when it is free
    a_tick_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !m_tvalid) |=> m_tvalid)
        else $error("captured tick did not reach the output stage");

endmodule

### hdl/pbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbs_cfg_regs
// Delay registers written through the plain write port.
// ----------------------------------------------------------------------------
module pbs_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pbs_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [pbs_pkg::DELAY_W-1:0]   cfg_data,
    output pbs_pkg::cfg_t                 cfg
);

    pbs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_hold_ms       <= pbs_pkg::ON_HOLD_RESET;
            cfg_reg.off_hold_ms      <= pbs_pkg::OFF_HOLD_RESET;
            cfg_reg.shutdown_wait_ms <= pbs_pkg::SHUTDOWN_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbs_pkg::REG_ON_HOLD:       cfg_reg.on_hold_ms       <= cfg_data;
                pbs_pkg::REG_OFF_HOLD:      cfg_reg.off_hold_ms      <= cfg_data;
                pbs_pkg::REG_SHUTDOWN_WAIT: cfg_reg.shutdown_wait_ms <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/pbs_core.sv
// ----------------------------------------------------------------------------
// pbs_core
// Sequencer state and the per-tick update: hold timing, shutdown timing and
// the output levels that follow from them.
// ----------------------------------------------------------------------------
module pbs_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              button_pressed,
    input  logic              low_voltage,
    input  pbs_pkg::cfg_t     cfg,
    output pbs_pkg::result_t  result
);

    logic                        system_on_reg,        system_on_next;
    logic                        shutdown_armed_reg,   shutdown_armed_next;
    logic                        hold_timing_reg,      hold_timing_next;
    logic [pbs_pkg::COUNT_W-1:0] hold_elapsed_reg,     hold_elapsed_next;
    logic                        shutdown_timing_reg,  shutdown_timing_next;
    logic [pbs_pkg::COUNT_W-1:0] shutdown_elapsed_reg, shutdown_elapsed_next;
    logic                        regulator_level_reg,  regulator_level_next;
    logic                        request_level_reg,    request_level_next;

    logic [pbs_pkg::COUNT_W:0]   hold_inc;
    logic [pbs_pkg::COUNT_W:0]   shutdown_inc;
    logic [pbs_pkg::COUNT_W-1:0] hold_sat;
    logic [pbs_pkg::COUNT_W-1:0] shutdown_sat;

    // Saturating increments: hold at all ones on carry out
    assign hold_inc     = {1'b0, hold_elapsed_reg} + 1'b1;
    assign shutdown_inc = {1'b0, shutdown_elapsed_reg} + 1'b1;
    assign hold_sat     = hold_inc[pbs_pkg::COUNT_W] ? hold_elapsed_reg
                                                     : hold_inc[pbs_pkg::COUNT_W-1:0];
    assign shutdown_sat = shutdown_inc[pbs_pkg::COUNT_W] ? shutdown_elapsed_reg
                                                         : shutdown_inc[pbs_pkg::COUNT_W-1:0];

    always_comb
    begin
        system_on_next        = system_on_reg;
        shutdown_armed_next   = shutdown_armed_reg;
        hold_timing_next      = hold_timing_reg;
        hold_elapsed_next     = hold_elapsed_reg;
        shutdown_timing_next  = shutdown_timing_reg;
        shutdown_elapsed_next = shutdown_elapsed_reg;
        regulator_level_next  = regulator_level_reg;
        request_level_next    = request_level_reg;

        // Hold timing runs only while the shutdown phase is not armed
        if (!shutdown_armed_reg)
        begin
            if (!button_pressed)
            begin
                hold_timing_next = 1'b0;
            end
            else if (!hold_timing_reg)
            begin
                hold_timing_next  = 1'b1;
                hold_elapsed_next = '0;
            end
            else
            begin
                hold_elapsed_next = hold_sat;
                if (!system_on_reg)
                begin
                    if (hold_sat > {1'b0, cfg.on_hold_ms})
                    begin
                        system_on_next       = 1'b1;
                        regulator_level_next = 1'b1;
                        hold_timing_next     = 1'b0;
                    end
                end
                else if (hold_sat > {1'b0, cfg.off_hold_ms})
                begin
                    system_on_next      = 1'b0;
                    request_level_next  = 1'b1;
                    hold_timing_next    = 1'b0;
                    shutdown_armed_next = 1'b1;
                end
            end
        end

        // Shutdown timer acts once per tick, while the phase is armed at tick start or low_voltage is set
        if (shutdown_armed_reg || low_voltage)
        begin
            if (!shutdown_timing_reg)
            begin
                shutdown_timing_next  = 1'b1;
                shutdown_elapsed_next = '0;
                request_level_next    = 1'b1;
            end
            else
            begin
                shutdown_elapsed_next = shutdown_sat;
                if (shutdown_sat > {1'b0, cfg.shutdown_wait_ms})
                begin
                    regulator_level_next = 1'b0;
                    request_level_next   = 1'b0;
                    shutdown_timing_next = 1'b0;
                    shutdown_armed_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_on_reg        <= 1'b0;
            shutdown_armed_reg   <= 1'b0;
            hold_timing_reg      <= 1'b0;
            hold_elapsed_reg     <= '0;
            shutdown_timing_reg  <= 1'b0;
            shutdown_elapsed_reg <= '0;
            regulator_level_reg  <= 1'b0;
            request_level_reg    <= 1'b0;
        end
        else if (step)
        begin
            system_on_reg        <= system_on_next;
            shutdown_armed_reg   <= shutdown_armed_next;
            hold_timing_reg      <= hold_timing_next;
            hold_elapsed_reg     <= hold_elapsed_next;
            shutdown_timing_reg  <= shutdown_timing_next;
            shutdown_elapsed_reg <= shutdown_elapsed_next;
            regulator_level_reg  <= regulator_level_next;
            request_level_reg    <= request_level_next;
        end
    end

    assign result.regulator_enable = regulator_level_next;
    assign result.shutdown_request = request_level_next;
    assign result.system_marked_on = system_on_next;
    assign result.shutting_down    = shutdown_armed_next || shutdown_timing_next;

endmodule
